/* sv/u8v_pkg.sv */
// u8v_pkg: types and constants shared by the utf-8 stream validator
// no dependencies; compile first
`default_nettype none

package u8v_pkg;

    localparam int unsigned CP_W = 21;

    // lead byte and continuation byte patterns
    localparam logic [7:0] C_ASCII_MAX = 8'h7F;
    localparam logic [7:0] C_MASK_2B   = 8'hE0;
    localparam logic [7:0] C_LEAD_2B   = 8'hC0;
    localparam logic [7:0] C_MASK_3B   = 8'hF0;
    localparam logic [7:0] C_LEAD_3B   = 8'hE0;
    localparam logic [7:0] C_MASK_4B   = 8'hF8;
    localparam logic [7:0] C_LEAD_4B   = 8'hF0;
    localparam logic [7:0] C_MASK_CONT = 8'hC0;
    localparam logic [7:0] C_CONT      = 8'h80;

    // code point limits
    localparam logic [CP_W-1:0] C_SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] C_SURR_HI = 21'h00DFFF;
    localparam logic [CP_W-1:0] C_CP_MAX  = 21'h10FFFF;

    // sequence length codes: bytes after the lead byte
    localparam logic [1:0] C_LEN_NONE = 2'd0;
    localparam logic [1:0] C_LEN_2B   = 2'd1;
    localparam logic [1:0] C_LEN_3B   = 2'd2;
    localparam logic [1:0] C_LEN_4B   = 2'd3;

    typedef struct packed {
        logic [1:0]      bytes_owed;
        logic [1:0]      sequence_length;
        logic [CP_W-1:0] partial_code_point;
        logic            error_seen;
    } t_state;

    typedef struct packed {
        t_state next_state;
        logic   verdict;
    } t_update;

endpackage

`default_nettype wire

/* sv/u8v_stream_if.sv */
// u8v_byte_if / u8v_verdict_if: valid/ready channels of the validator
// no dependencies
`default_nettype none

interface u8v_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_string;

    modport source (output valid, output data_byte, output end_of_string, input ready);
    modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface u8v_verdict_if;
    logic valid;
    logic ready;
    logic string_valid;

    modport source (output valid, output string_valid, input ready);
    modport sink   (input valid, input string_valid, output ready);
endinterface

`default_nettype wire

/* sv/u8v_update.sv */
// u8v_update: per-byte decode step, state and byte in, next state and verdict out
// depends on u8v_pkg
`default_nettype none

module u8v_update (
    input  wire u8v_pkg::t_state  i_state,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_last,
    output u8v_pkg::t_update      o_update
);

    u8v_pkg::t_state s;
    logic [u8v_pkg::CP_W-1:0] cp_shift;
    logic [1:0] owed_dec;

    assign cp_shift = {i_state.partial_code_point[u8v_pkg::CP_W-7:0], i_byte[5:0]};
    assign owed_dec = i_state.bytes_owed - 2'd1;

    always_comb begin
        s = i_state;
        if (i_state.bytes_owed == 2'd0) begin
            // lead byte
            if (i_byte <= u8v_pkg::C_ASCII_MAX) begin
                s = i_state;
            end else if ((i_byte & u8v_pkg::C_MASK_2B) == u8v_pkg::C_LEAD_2B) begin
                s.bytes_owed         = 2'd1;
                s.sequence_length    = u8v_pkg::C_LEN_2B;
                s.partial_code_point = {16'd0, i_byte[4:0]};
            end else if ((i_byte & u8v_pkg::C_MASK_3B) == u8v_pkg::C_LEAD_3B) begin
                s.bytes_owed         = 2'd2;
                s.sequence_length    = u8v_pkg::C_LEN_3B;
                s.partial_code_point = {17'd0, i_byte[3:0]};
            end else if ((i_byte & u8v_pkg::C_MASK_4B) == u8v_pkg::C_LEAD_4B) begin
                s.bytes_owed         = 2'd3;
                s.sequence_length    = u8v_pkg::C_LEN_4B;
                s.partial_code_point = {18'd0, i_byte[2:0]};
            end else begin
                s.error_seen = 1'b1;
            end
        end else if ((i_byte & u8v_pkg::C_MASK_CONT) != u8v_pkg::C_CONT) begin
            // broken sequence: drop it, keep the error
            s.error_seen         = 1'b1;
            s.bytes_owed         = 2'd0;
            s.sequence_length    = u8v_pkg::C_LEN_NONE;
            s.partial_code_point = '0;
        end else begin
            s.bytes_owed         = owed_dec;
            s.partial_code_point = cp_shift;
            if (owed_dec == 2'd0) begin
                // sequence complete: range checks
                if (i_state.sequence_length == u8v_pkg::C_LEN_3B
                        && cp_shift >= u8v_pkg::C_SURR_LO
                        && cp_shift <= u8v_pkg::C_SURR_HI) begin
                    s.error_seen = 1'b1;
                end
                if (i_state.sequence_length == u8v_pkg::C_LEN_4B
                        && cp_shift > u8v_pkg::C_CP_MAX) begin
                    s.error_seen = 1'b1;
                end
                s.sequence_length    = u8v_pkg::C_LEN_NONE;
                s.partial_code_point = '0;
            end
        end

        o_update.verdict    = !s.error_seen && (s.bytes_owed == 2'd0);
        o_update.next_state = i_last ? '0 : s;
    end

endmodule

`default_nettype wire

/* sv/u8v_result_reg.sv */
// u8v_result_reg: output register holding one verdict until the sink takes it
// depends on u8v_stream_if
`default_nettype none

module u8v_result_reg (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  wire logic      i_verdict,
    output logic           o_free,
    u8v_verdict_if.source  o_out
);

    logic r_valid;
    logic n_valid;
    logic r_verdict;

    // free when empty or being emptied this cycle
    assign o_free  = !r_valid || o_out.ready;
    assign n_valid = i_load || (r_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_verdict <= i_verdict;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.string_valid = r_verdict;

endmodule

`default_nettype wire

/* sv/utf8_stream_validator_unit.sv */
// utf8_stream_validator_unit: checks a byte stream for valid utf-8, one verdict per string
// depends on u8v_pkg, u8v_stream_if, u8v_update, u8v_result_reg
//
// channel    dir  handshake        word
// i_in       in   valid/ready      data_byte[7:0], end_of_string
// o_out      out  valid/ready      string_valid
//
// one word per cycle unless a final byte waits on a stalled verdict; the verdict follows
// the final byte via the input register, then the decode step into the result register
// the decode step updates the small state register for each word that moves on, so each
// byte sees the state left by the byte before it
// reset clears the input register, the state and the result register
// a stalled verdict only blocks a final byte; other bytes keep flowing

`default_nettype none

module utf8_stream_validator_unit (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    u8v_byte_if.sink      i_in,
    u8v_verdict_if.source o_out
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // decode state
    u8v_pkg::t_state  r_state;
    u8v_pkg::t_update upd;

    logic out_free;
    logic advance;     // the word in the input register moves on this cycle
    logic load_result; // a final word drops its verdict into the result register

    // a non-final word never needs the result register
    assign advance     = r_in_valid && (!r_in_last || out_free);
    assign load_result = advance && r_in_last;
    assign i_in.ready  = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.end_of_string;
        end
    end

    u8v_update u_update (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_update (upd)
    );

    // state follows the word that leaves the input register; cleared after a final word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= upd.next_state;
        end
    end

    u8v_result_reg u_result (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load_result),
        .i_verdict (upd.verdict),
        .o_free    (out_free),
        .o_out     (o_out)
    );

    // no sequence open means nothing gathered
    a_idle_state_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bytes_owed == 2'd0 |->
            (r_state.sequence_length == u8v_pkg::C_LEN_NONE
             && r_state.partial_code_point == '0))
        else $error("owed count zero but sequence state left over");

    // owed count never exceeds the sequence length
    a_owed_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bytes_owed <= r_state.sequence_length)
        else $error("more bytes owed than the sequence holds");

    // a final word leaves the decoder in its reset state
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_result |=> r_state == '0)
        else $error("state not cleared after final word");

    // a final word only moves when the result register can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !load_result)
        else $error("verdict loaded over a pending one");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// tb_top: self-checking testbench for utf8_stream_validator_unit
// depends on u8v_pkg, u8v_byte_if, u8v_verdict_if and the validator rtl
`timescale 1ns / 100ps

module tb_top;

    typedef logic [7:0] t_byte_q[$];

    logic clk;
    logic rst_n;

    u8v_byte_if    byte_ch ();
    u8v_verdict_if verdict_ch ();

    utf8_stream_validator_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_ch),
        .o_out   (verdict_ch)
    );

    // idle percentages for each side, changed between phases
    int unsigned src_gap_pct;
    int unsigned sink_gap_pct;
    int unsigned mismatches;

    // decoder state mirrored by the testbench
    logic [1:0]               owed_cnt;
    logic [1:0]               seq_len;
    logic [u8v_pkg::CP_W-1:0] cp_acc;
    logic                     err_flag;

    // verdicts predicted but not yet seen on the output
    logic verdicts_due[$];

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    // update the mirrored state with one accepted word; a final byte yields a verdict
    task automatic decode_byte(input logic [7:0] b, input logic last);
        if (owed_cnt == 2'd0) begin
            if (b <= u8v_pkg::C_ASCII_MAX) begin
                // plain ascii, nothing to track
            end else if ((b & u8v_pkg::C_MASK_2B) == u8v_pkg::C_LEAD_2B) begin
                owed_cnt = 2'd1;
                seq_len  = u8v_pkg::C_LEN_2B;
                cp_acc   = {16'd0, b[4:0]};
            end else if ((b & u8v_pkg::C_MASK_3B) == u8v_pkg::C_LEAD_3B) begin
                owed_cnt = 2'd2;
                seq_len  = u8v_pkg::C_LEN_3B;
                cp_acc   = {17'd0, b[3:0]};
            end else if ((b & u8v_pkg::C_MASK_4B) == u8v_pkg::C_LEAD_4B) begin
                owed_cnt = 2'd3;
                seq_len  = u8v_pkg::C_LEN_4B;
                cp_acc   = {18'd0, b[2:0]};
            end else begin
                // stray continuation or f8..ff
                err_flag = 1'b1;
            end
        end else if ((b & u8v_pkg::C_MASK_CONT) != u8v_pkg::C_CONT) begin
            // broken sequence: drop it, later bytes are read as lead bytes
            err_flag = 1'b1;
            owed_cnt = 2'd0;
            seq_len  = u8v_pkg::C_LEN_NONE;
            cp_acc   = '0;
        end else begin
            cp_acc   = {cp_acc[u8v_pkg::CP_W-7:0], b[5:0]};
            owed_cnt = owed_cnt - 2'd1;
            if (owed_cnt == 2'd0) begin
                if (seq_len == u8v_pkg::C_LEN_3B && cp_acc >= u8v_pkg::C_SURR_LO
                        && cp_acc <= u8v_pkg::C_SURR_HI) begin
                    err_flag = 1'b1;
                end
                if (seq_len == u8v_pkg::C_LEN_4B && cp_acc > u8v_pkg::C_CP_MAX) begin
                    err_flag = 1'b1;
                end
                seq_len = u8v_pkg::C_LEN_NONE;
                cp_acc  = '0;
            end
        end

        if (last) begin
            verdicts_due.push_back(!err_flag && owed_cnt == 2'd0);
            owed_cnt = 2'd0;
            seq_len  = u8v_pkg::C_LEN_NONE;
            cp_acc   = '0;
            err_flag = 1'b0;
        end
    endtask

    // drive one word at the falling edge, hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_gap_pct) begin
            byte_ch.valid = 1'b0;
            @(negedge clk);
        end
        byte_ch.valid         = 1'b1;
        byte_ch.data_byte     = b;
        byte_ch.end_of_string = last;
        do @(posedge clk); while (!byte_ch.ready);
        decode_byte(b, last);
    endtask

    task automatic send_string(input t_byte_q str);
        int unsigned i;
        for (i = 0; i < str.size(); i++) begin
            send_byte(str[i], i == str.size() - 1);
        end
    endtask

    // sink side: ready toggles at the falling edge
    always @(negedge clk) begin
        verdict_ch.ready = ($urandom_range(0, 99) >= sink_gap_pct);
    end

    // compare each accepted verdict with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && verdict_ch.valid && verdict_ch.ready) begin
            if (verdicts_due.size() == 0) begin
                report_mismatch($sformatf("verdict %0b with none expected",
                                          verdict_ch.string_valid));
            end else if (verdict_ch.string_valid !== verdicts_due[0]) begin
                report_mismatch($sformatf("string_valid got %b expected %b",
                                          verdict_ch.string_valid, verdicts_due[0]));
                void'(verdicts_due.pop_front());
            end else begin
                void'(verdicts_due.pop_front());
            end
        end
    end

    // ascii extremes and lone bad lead bytes
    task automatic test_single_bytes();
        send_string('{8'h00});
        send_string('{8'h7F});
        send_string('{8'h80});
        send_string('{8'hFF});
    endtask

    // well-formed 2-, 3- and 4-byte forms, overlong accepted
    task automatic test_multibyte_forms();
        send_string('{8'hC3, 8'hA9});
        send_string('{8'hE0, 8'h80, 8'h80});
        send_string('{8'hF4, 8'h8F, 8'hBF, 8'hBF});
    endtask

    // surrogate block and code points past the unicode limit
    task automatic test_range_errors();
        send_string('{8'hED, 8'hA0, 8'h80});
        send_string('{8'hF4, 8'h90, 8'h80, 8'h80});
    endtask

    // truncated string, bad continuation, error followed by more bytes
    task automatic test_broken_sequences();
        send_string('{8'hE2, 8'h82});
        send_string('{8'hC3, 8'h41});
        send_string('{8'hF8, 8'h41});
    endtask

    // strings built mostly from well-formed sequences with random payload,
    // mixed with noise bytes, truncations and corrupted continuations
    task automatic test_random_strings(input int unsigned byte_budget);
        t_byte_q     str;
        int unsigned sent;
        int unsigned units;
        int unsigned kind;
        int unsigned len;
        int unsigned k;
        logic [7:0]  lead;
        sent = 0;
        while (sent < byte_budget) begin
            str.delete();
            units = $urandom_range(1, 5);
            repeat (units) begin
                kind = $urandom_range(0, 19);
                if (kind < 2) begin
                    str.push_back(8'($urandom_range(0, 255)));
                end else begin
                    len = $urandom_range(1, 4);
                    case (len)
                        1: lead = 8'($urandom_range(0, 127));
                        2: lead = 8'hC0 + 8'($urandom_range(0, 31));
                        3: lead = 8'hE0 + 8'($urandom_range(0, 15));
                        default: lead = 8'hF0 + 8'($urandom_range(0, 7));
                    endcase
                    // steer some forms toward the range limits
                    if (len == 3 && kind < 5) lead = 8'hED;
                    if (len == 4 && kind < 5) lead = 8'hF4;
                    str.push_back(lead);
                    for (k = 1; k < len; k++) begin
                        str.push_back(8'h80 + 8'($urandom_range(0, 63)));
                    end
                    if (len > 1 && kind == 19) begin
                        void'(str.pop_back());
                    end else if (len > 1 && kind == 18) begin
                        str[str.size() - 1] = 8'($urandom_range(0, 255));
                    end
                end
            end
            sent += str.size();
            send_string(str);
        end
    endtask

    initial begin
        rst_n                    = 1'b0;
        byte_ch.valid            = 1'b0;
        byte_ch.data_byte        = 8'h00;
        byte_ch.end_of_string    = 1'b0;
        verdict_ch.ready         = 1'b0;
        src_gap_pct              = 29;
        sink_gap_pct             = 48;
        mismatches               = 0;
        owed_cnt                 = 2'd0;
        seq_len                  = u8v_pkg::C_LEN_NONE;
        cp_acc                   = '0;
        err_flag                 = 1'b0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_single_bytes();
        test_multibyte_forms();
        test_range_errors();
        test_broken_sequences();
        test_random_strings(520);

        src_gap_pct  = 48;
        sink_gap_pct = 29;
        test_random_strings(520);

        src_gap_pct  = 0;
        sink_gap_pct = 0;
        test_random_strings(520);

        @(negedge clk);
        byte_ch.valid = 1'b0;

        // drain, then wait for anything unexpected to show up
        wait (verdicts_due.size() == 0);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && verdicts_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
